// ===== hdl/mvsr_pkg.sv =====
`timescale 1ns / 1ps

package mvsr_pkg;

    // Fixed field and register widths
    localparam int COL_CFG_W  = 9;
    localparam int ROW_CFG_W  = 13;
    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IDX_W      = 8;
    localparam int RESULT_W   = 32;
    localparam int ROW_IDX_W  = 12;
    localparam int ACC_W      = 40;

    localparam logic [COL_CFG_W-1:0] COL_CFG_RESET = 9'd256;
    localparam logic [ROW_CFG_W-1:0] ROW_CFG_RESET = 13'd1;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_COUNT = 2'd0,
        CFG_ROW_COUNT    = 2'd1,
        CFG_SCALE_FACTOR = 2'd2
    } cfg_index_t;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_MATRIX = 1'b1
    } func_t;

    // Travels with a row sum down the requant pipe
    typedef struct packed {
        logic                 valid;
        logic                 last_row;
        logic [ROW_IDX_W-1:0] row_index;
    } row_tag_t;

endpackage

// ===== hdl/mvsr_vec_mac.sv =====
`timescale 1ns / 1ps

module mvsr_vec_mac #(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_ROWS      = 4096,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic                                   func,
    input  logic [mvsr_pkg::IDX_W-1:0]             elem_index,
    input  logic signed [ELEMENT_WIDTH-1:0]        value,
    input  logic [mvsr_pkg::COL_CFG_W-1:0]         col_cfg,
    input  logic [mvsr_pkg::ROW_CFG_W-1:0]         row_cfg,
    output mvsr_pkg::row_tag_t                     sum_tag,
    output logic signed [mvsr_pkg::ACC_W-1:0]      row_sum
);
    import mvsr_pkg::*;

    localparam int AW     = $clog2(MAX_COLUMNS);
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W = 2 * ELEMENT_WIDTH;

    logic signed [ELEMENT_WIDTH-1:0] vec_mem [MAX_COLUMNS];
    logic signed [ELEMENT_WIDTH-1:0] rdata_reg;

    logic [AW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;

    logic is_load, is_matrix, load_ok, col_end, row_last;

    row_tag_t                        s1_tag_reg, s2_tag_reg, q_tag_reg;
    logic                            s1_end_reg, s2_end_reg;
    logic signed [ELEMENT_WIDTH-1:0] s1_value_reg;
    logic signed [PROD_W-1:0]        s2_prod_reg;
    logic signed [ACC_W-1:0]         acc_reg, acc_next, q_sum_reg;

    assign is_load   = in_valid && (func == FUNC_LOAD);
    assign is_matrix = in_valid && (func == FUNC_MATRIX);
    assign load_ok   = 32'(elem_index) < 32'(MAX_COLUMNS);

    // cfg of 0 acts as 1 for free: count+1 is never below 1
    assign col_end  = (32'(col_cnt_reg) + 32'd1 >= 32'(col_cfg)) ||
                      (32'(col_cnt_reg) + 32'd1 >= 32'(MAX_COLUMNS));
    assign row_last = (32'(row_cnt_reg) + 32'd1 >= 32'(row_cfg)) ||
                      (32'(row_cnt_reg) + 32'd1 >= 32'(MAX_ROWS));

    always_comb begin
        col_cnt_next = col_end ? '0 : col_cnt_reg + AW'(1);
        row_cnt_next = row_cnt_reg;
        if (col_end) begin
            row_cnt_next = row_last ? '0 : row_cnt_reg + RW'(1);
        end
    end

    // Vector store: one write port (loads), one registered read port (matrix).
    // A load always lands before any later matrix read.
    always_ff @(posedge aclk) begin
        if (is_load && load_ok) begin
            vec_mem[AW'(elem_index)] <= value;
        end
        if (is_matrix) begin
            rdata_reg <= vec_mem[col_cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (is_matrix) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    assign acc_next = acc_reg + ACC_W'(s2_prod_reg);

    // valids and accumulator reset; tag payload and data just follow en
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg.valid <= 1'b0;
            s2_tag_reg.valid <= 1'b0;
            q_tag_reg.valid  <= 1'b0;
            acc_reg          <= '0;
        end else if (en) begin
            s1_tag_reg.valid <= is_matrix;
            s2_tag_reg.valid <= s1_tag_reg.valid;
            q_tag_reg.valid  <= s2_tag_reg.valid && s2_end_reg;
            if (s2_tag_reg.valid) begin
                acc_reg <= s2_end_reg ? '0 : acc_next;
            end
        end
        if (en) begin
            if (is_matrix) begin
                s1_value_reg        <= value;
                s1_end_reg          <= col_end;
                s1_tag_reg.last_row <= row_last;
                s1_tag_reg.row_index <= ROW_IDX_W'(row_cnt_reg);
            end
            s2_prod_reg          <= s1_value_reg * rdata_reg;
            s2_end_reg           <= s1_end_reg;
            s2_tag_reg.last_row  <= s1_tag_reg.last_row;
            s2_tag_reg.row_index <= s1_tag_reg.row_index;
            q_sum_reg            <= acc_next;
            q_tag_reg.last_row   <= s2_tag_reg.last_row;
            q_tag_reg.row_index  <= s2_tag_reg.row_index;
        end
    end

    assign sum_tag = q_tag_reg;
    assign row_sum = q_sum_reg;

endmodule

// ===== hdl/mvsr_requant.sv =====
`timescale 1ns / 1ps

module mvsr_requant (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  mvsr_pkg::row_tag_t                    in_tag,
    input  logic signed [mvsr_pkg::ACC_W-1:0]     row_sum,
    input  logic [mvsr_pkg::SCALE_W-1:0]          scale,
    output mvsr_pkg::row_tag_t                    out_tag,
    output logic signed [mvsr_pkg::RESULT_W-1:0]  result
);
    import mvsr_pkg::*;

    localparam int LO_W   = ACC_W / 2;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int PROD_W = ACC_W + SCALE_W;
    localparam int R_W    = PROD_W - SCALE_FRAC;

    localparam logic [PROD_W-1:0] HALF_LSB  = PROD_W'(1) << (SCALE_FRAC - 1);
    localparam logic [R_W-1:0]    POS_LIMIT = R_W'(64'h7FFF_FFFF);
    localparam logic [R_W-1:0]    NEG_LIMIT = R_W'(64'h8000_0000);

    row_tag_t                    m_tag_reg, p_tag_reg, r_tag_reg;
    logic                        m_neg_reg, p_neg_reg, r_neg_reg;
    logic [ACC_W-1:0]            mag_reg;
    logic [LO_W+SCALE_W-1:0]     p_lo_reg;
    logic [HI_W+SCALE_W-1:0]     p_hi_reg;
    logic [PROD_W-1:0]           rounded;
    logic [R_W-1:0]              r_reg;

    // full product split in two partial products, joined with the rounding add
    assign rounded = (PROD_W'(p_hi_reg) << LO_W) + PROD_W'(p_lo_reg) + HALF_LSB;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tag_reg.valid <= 1'b0;
            p_tag_reg.valid <= 1'b0;
            r_tag_reg.valid <= 1'b0;
        end else if (en) begin
            m_tag_reg.valid <= in_tag.valid;
            p_tag_reg.valid <= m_tag_reg.valid;
            r_tag_reg.valid <= p_tag_reg.valid;
        end
        if (en) begin
            m_tag_reg.last_row  <= in_tag.last_row;
            m_tag_reg.row_index <= in_tag.row_index;
            m_neg_reg           <= row_sum[ACC_W-1];
            mag_reg             <= row_sum[ACC_W-1] ? ACC_W'(-row_sum) : ACC_W'(row_sum);

            p_tag_reg.last_row  <= m_tag_reg.last_row;
            p_tag_reg.row_index <= m_tag_reg.row_index;
            p_neg_reg           <= m_neg_reg;
            p_lo_reg            <= mag_reg[LO_W-1:0] * scale;
            p_hi_reg            <= mag_reg[ACC_W-1:LO_W] * scale;

            r_tag_reg.last_row  <= p_tag_reg.last_row;
            r_tag_reg.row_index <= p_tag_reg.row_index;
            r_neg_reg           <= p_neg_reg;
            r_reg               <= rounded[PROD_W-1:SCALE_FRAC];
        end
    end

    // saturate, then restore sign
    always_comb begin
        if (r_neg_reg) begin
            result = (r_reg > NEG_LIMIT) ? RESULT_W'(NEG_LIMIT)
                                         : -RESULT_W'(r_reg);
        end else begin
            result = (r_reg > POS_LIMIT) ? RESULT_W'(POS_LIMIT) : RESULT_W'(r_reg);
        end
    end

    assign out_tag = r_tag_reg;

endmodule

// ===== hdl/matvec_scale_round.sv =====
`timescale 1ns / 1ps
// matvec_scale_round: matrix-vector product with requantized row results.
//
// Input channel (s_*): each word is either a vector load (s_func = 0, writes
// s_value at s_elem_index into the vector store) or the next matrix element
// in row-major order (s_func = 1). Load the vector before streaming rows.
// Result channel (m_*): one word per completed row: the row sum times the
// Q8.16 scale, rounded half away from zero, saturated to 32-bit signed, with
// its row index and a last-row flag. Loads produce no result.
// Config channel (cfg_*): column count, row count, scale; write only while
// the block is idle. cfg_ready is always high.
//
// Throughput: one word per cycle while no result waits on m_ready, set by one
// vector store read per matrix word feeding one multiply-accumulate per element.
// A row's final element passes s1 and s2, its sum q, m, p, r and the output register.
// Reset: counters, accumulator and valids clear; registers return to 256
// columns, 1 row, scale 1.0. The vector store is not cleared.
// Stall: while a result waits on m_ready, the whole pipe freezes and s_ready
// drops; it never drops otherwise.

module matvec_scale_round #(
    parameter int MAX_COLUMNS   = 256,
    parameter int MAX_ROWS      = 4096,
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [mvsr_pkg::IDX_W-1:0]            s_elem_index,
    input  logic signed [ELEMENT_WIDTH-1:0]       s_value,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mvsr_pkg::RESULT_W-1:0]  m_result_value,
    output logic [mvsr_pkg::ROW_IDX_W-1:0]        m_row_index,
    output logic                                  m_last_row,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mvsr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mvsr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mvsr_pkg::*;

    logic [COL_CFG_W-1:0] col_cfg_reg;
    logic [ROW_CFG_W-1:0] row_cfg_reg;
    logic [SCALE_W-1:0]   scale_reg;

    logic advance;

    row_tag_t                sum_tag, res_tag;
    logic signed [ACC_W-1:0] row_sum;
    logic signed [RESULT_W-1:0] result;

    logic                       m_valid_reg;
    logic signed [RESULT_W-1:0] m_result_value_reg;
    logic [ROW_IDX_W-1:0]       m_row_index_reg;
    logic                       m_last_row_reg;

    // pipe moves unless a finished word is held by the receiver
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cfg_reg <= COL_CFG_RESET;
            row_cfg_reg <= ROW_CFG_RESET;
            scale_reg   <= SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COLUMN_COUNT: col_cfg_reg <= cfg_data[COL_CFG_W-1:0];
                CFG_ROW_COUNT:    row_cfg_reg <= cfg_data[ROW_CFG_W-1:0];
                CFG_SCALE_FACTOR: scale_reg   <= cfg_data[SCALE_W-1:0];
                default: ; // unused index, dropped
            endcase
        end
    end

    mvsr_vec_mac #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .in_valid   (s_valid && advance),
        .func       (s_func),
        .elem_index (s_elem_index),
        .value      (s_value),
        .col_cfg    (col_cfg_reg),
        .row_cfg    (row_cfg_reg),
        .sum_tag    (sum_tag),
        .row_sum    (row_sum)
    );

    mvsr_requant u_requant (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .in_tag  (sum_tag),
        .row_sum (row_sum),
        .scale   (scale_reg),
        .out_tag (res_tag),
        .result  (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_tag.valid) begin
            m_result_value_reg <= result;
            m_row_index_reg    <= res_tag.row_index;
            m_last_row_reg     <= res_tag.last_row;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_row_index    = m_row_index_reg;
    assign m_last_row     = m_last_row_reg;

endmodule

// ===== hdl/mvsr_checker.sv =====
`timescale 1ns / 1ps

module mvsr_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [mvsr_pkg::RESULT_W-1:0]  m_result_value,
    input logic [mvsr_pkg::ROW_IDX_W-1:0]        m_row_index,
    input logic                                  m_last_row,
    input logic                                  cfg_ready
);
    import mvsr_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) &&
                                $stable(m_row_index) && $stable(m_last_row))
        else $error("stalled result word changed");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without an output stall");

    a_cfg_always_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind matvec_scale_round mvsr_checker u_mvsr_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import mvsr_pkg::*;

    localparam int STORE_DEPTH   = 256;   // vector store depth, also the column limit
    localparam int ROW_LIMIT     = 4096;
    localparam int SETTLE_CYCLES = 20;    // margin for the result pipe to empty
    localparam int HOLD_CYCLES   = 60;    // long receiver hold-off
    localparam int RANDOM_WORDS  = 120;

    // One input word as queued for the driver
    typedef struct {
        func_t                   func;
        logic [IDX_W-1:0]        idx;
        logic signed [15:0]      val;
    } in_word_t;

    // One predicted row result
    typedef struct {
        logic signed [RESULT_W-1:0] result;
        logic [ROW_IDX_W-1:0]       row;
        logic                       last_flag;
    } row_result_t;

    // DUT ports; every input starts at a known value
    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_func = 1'b0;
    logic [IDX_W-1:0]             s_elem_index = '0;
    logic signed [15:0]           s_value = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [RESULT_W-1:0]   m_result_value;
    logic [ROW_IDX_W-1:0]         m_row_index;
    logic                         m_last_row;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    // Stimulus plumbing
    in_word_t      input_words[$];
    row_result_t   expected_rows[$];
    int unsigned   words_queued = 0;
    int unsigned   words_accepted = 0;
    int unsigned   mismatches = 0;
    int unsigned   tx_idle_pct = 27;
    int unsigned   rx_idle_pct = 72;
    logic          hold_go = 1'b0;
    logic          rx_hold = 1'b0;

    // Shadow of the block: registers, vector store, row accumulator, counters
    logic [COL_CFG_W-1:0]    cols_reg = COL_CFG_RESET;
    logic [ROW_CFG_W-1:0]    rows_reg = ROW_CFG_RESET;
    logic [SCALE_W-1:0]      scale_reg = SCALE_RESET;
    logic signed [15:0]      vec_mem [STORE_DEPTH];
    logic [ACC_W-1:0]        row_acc = '0;
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;

    matvec_scale_round uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_elem_index   (s_elem_index),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_row_index    (m_row_index),
        .m_last_row     (m_last_row),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Requantize a 40-bit row sum: |sum| * Q8.16 scale, round half away from
    // zero, then saturate to signed 32 bits.
    function automatic logic signed [RESULT_W-1:0] scale_round(input logic [ACC_W-1:0] acc,
                                                                input logic [SCALE_W-1:0] scale);
        longint          sum;
        longint unsigned mag;
        longint unsigned rounded;
        sum = longint'(signed'(acc));
        mag = (sum < 0) ? -sum : sum;
        rounded = (mag * scale + 64'd32768) >> SCALE_FRAC;
        if (sum < 0) begin
            if (rounded > 64'd2147483648)
                rounded = 64'd2147483648;
            rounded = -rounded;
            return rounded[RESULT_W-1:0];
        end
        if (rounded > 64'd2147483647)
            rounded = 64'd2147483647;
        return rounded[RESULT_W-1:0];
    endfunction

    // Advance the shadow by one accepted word; queue a row result when a row closes.
    task automatic mac_predict(input func_t func, input logic [IDX_W-1:0] idx,
                               input logic signed [15:0] val);
        row_result_t r;
        longint      p;
        int unsigned cols_eff;
        int unsigned rows_eff;
        if (func == FUNC_LOAD) begin
            vec_mem[idx] = val;
            return;
        end
        if (col_pos < STORE_DEPTH) begin
            p = longint'(val) * longint'(vec_mem[col_pos]);
            row_acc = row_acc + p[ACC_W-1:0];   // wraps at 40 bits
        end
        col_pos++;
        // out-of-range register values clamp to the legal span
        cols_eff = (cols_reg == 0) ? 1 : ((cols_reg > STORE_DEPTH) ? STORE_DEPTH : cols_reg);
        rows_eff = (rows_reg == 0) ? 1 : ((rows_reg > ROW_LIMIT) ? ROW_LIMIT : rows_reg);
        if (col_pos < cols_eff)
            return;
        r.result    = scale_round(row_acc, scale_reg);
        r.row       = row_pos[ROW_IDX_W-1:0];
        r.last_flag = (row_pos + 1) >= rows_eff;
        expected_rows.push_back(r);
        row_acc = '0;
        col_pos = 0;
        row_pos = r.last_flag ? 0 : row_pos + 1;
    endtask

    // Input driver: presents queued words, idles at random between them.
    always @(posedge aclk) begin : drive_words
        in_word_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                mac_predict(func_t'(s_func), s_elem_index, s_value);
                words_accepted++;
            end
            // payload only moves once the current word is taken
            if (!s_valid || s_ready) begin
                if (input_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = input_words.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= nxt.func;
                    s_elem_index <= nxt.idx;
                    s_value      <= nxt.val;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, checks each word against the oldest prediction.
    always @(posedge aclk) begin : check_results
        row_result_t want;
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected result word: value %0d row %0d last %0b",
                         $time, m_result_value, m_row_index, m_last_row);
                mismatches++;
            end else begin
                want = expected_rows.pop_front();
                if (m_result_value !== want.result) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.result, m_result_value);
                    mismatches++;
                end
                if (m_row_index !== want.row) begin
                    $display("%0t: row_index expected %0d actual %0d",
                             $time, want.row, m_row_index);
                    mismatches++;
                end
                if (m_last_row !== want.last_flag) begin
                    $display("%0t: last_row expected %0b actual %0b",
                             $time, want.last_flag, m_last_row);
                    mismatches++;
                end
            end
        end
    end

    // Long receiver hold-off, counted here; the sender keeps offering meanwhile
    // so the pipe fills and s_ready must drop.
    initial begin : rx_hold_off
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL matvec_scale_round");
        $finish;
    end

    task automatic queue_word(input func_t func, input logic [IDX_W-1:0] idx,
                              input logic signed [15:0] val);
        in_word_t w;
        w.func = func;
        w.idx  = idx;
        w.val  = val;
        input_words.push_back(w);
        words_queued++;
    endtask

    // Mostly random, with a fair share of the extremes
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sender stops until every word is taken and every result is back,
    // then the pipe gets time to empty (loads leave nothing to wait on).
    task automatic wait_drained();
        while (words_accepted != words_queued || expected_rows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back, valid held high throughout.
    task automatic program_regs(input int unsigned cols,
                                input int unsigned rows,
                                input int unsigned scale);
        cfg_index_t            order [3];
        logic [CFG_DATA_W-1:0] vals [3];
        order = '{CFG_COLUMN_COUNT, CFG_ROW_COUNT, CFG_SCALE_FACTOR};
        vals  = '{CFG_DATA_W'(cols), CFG_DATA_W'(rows), CFG_DATA_W'(scale)};
        cfg_valid <= 1'b1;
        foreach (order[i]) begin
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (order[i])
                CFG_COLUMN_COUNT: cols_reg  = vals[i][COL_CFG_W-1:0];
                CFG_ROW_COUNT:    rows_reg  = vals[i][ROW_CFG_W-1:0];
                CFG_SCALE_FACTOR: scale_reg = vals[i][SCALE_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned random_words;
        int unsigned cols;
        int unsigned rows;
        int unsigned scale;
        int unsigned n_words;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole store first so no later read ever hits an unwritten
        // entry. Half a row runs under the reset registers (256 columns, so
        // no result yet), then a column count above the store depth clamps
        // and closes the row at 256 elements.
        for (int i = 0; i < STORE_DEPTH; i++)
            queue_word(FUNC_LOAD, IDX_W'(i), pick_value());
        for (int i = 0; i < STORE_DEPTH / 2; i++)
            queue_word(FUNC_MATRIX, IDX_W'($urandom_range(255)), pick_value());
        wait_drained();
        program_regs($urandom_range(STORE_DEPTH + 1, 511), 1, 65536);
        for (int i = 0; i < STORE_DEPTH / 2; i++)
            queue_word(FUNC_MATRIX, IDX_W'($urandom_range(255)), pick_value());
        wait_drained();

        // Directed: saturation both ways at max scale, store index extremes
        program_regs(2, 3, 'hFFFFFF);
        queue_word(FUNC_LOAD, 8'd0, 16'sh8000);
        queue_word(FUNC_LOAD, 8'd1, 16'sh8000);
        queue_word(FUNC_LOAD, 8'd255, 16'sh7FFF);
        queue_word(FUNC_MATRIX, 8'd0, 16'sh8000);
        queue_word(FUNC_MATRIX, 8'd255, 16'sh8000);    // large positive -> clamps high
        queue_word(FUNC_MATRIX, 8'd0, 16'sh7FFF);
        queue_word(FUNC_MATRIX, 8'd0, 16'sh7FFF);      // large negative -> clamps low
        queue_word(FUNC_MATRIX, 8'd0, 16'sh0000);
        queue_word(FUNC_MATRIX, 8'd0, 16'sh0000);      // zero row, flagged last
        wait_drained();

        // Scale 0.5: exact halves round away from zero
        program_regs(1, 2, 32768);
        queue_word(FUNC_LOAD, 8'd0, 16'sd1);
        queue_word(FUNC_MATRIX, 8'd0, 16'sd3);
        queue_word(FUNC_MATRIX, 8'd0, -16'sd3);
        queue_word(FUNC_MATRIX, 8'd0, 16'sd1);
        queue_word(FUNC_MATRIX, 8'd0, -16'sd1);
        wait_drained();

        // Zero scale
        program_regs(1, 1, 0);
        queue_word(FUNC_MATRIX, 8'd0, 16'sh7FFF);
        queue_word(FUNC_MATRIX, 8'd0, 16'sh8000);
        wait_drained();

        // Back-pressure: one result per word, sender never idles, receiver
        // held off long enough for the pipe to fill and stall the input.
        program_regs(1, 5, $urandom_range(0, 'hFFFFFF));
        tx_idle_pct = 0;
        hold_go = 1'b1;
        for (int i = 0; i < 40; i++)
            queue_word(FUNC_MATRIX, IDX_W'($urandom_range(255)), pick_value());
        wait_drained();

        // Random phases; each ends idle so registers can change, which also
        // leaves rows half done when the counts move under them.
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            if (random_words < RANDOM_WORDS / 3) begin
                tx_idle_pct = 27;
                rx_idle_pct = 72;
            end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 72;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case ($urandom_range(99)) inside
                [0:74]:  cols = $urandom_range(1, 6);
                [75:94]: cols = $urandom_range(7, 40);
                default: cols = 0;                        // acts as one column
            endcase
            case ($urandom_range(99)) inside
                [0:74]:  rows = $urandom_range(1, 6);
                [75:84]: rows = $urandom_range(7, 40);
                [85:89]: rows = 0;
                [90:94]: rows = ROW_LIMIT;
                default: rows = $urandom_range(ROW_LIMIT + 1, 8191);
            endcase
            case ($urandom_range(5))
                0:       scale = 65536;
                1:       scale = 0;
                2:       scale = 'hFFFFFF;
                3:       scale = $urandom_range(0, 'hFFFFFF);
                4:       scale = 32768;
                default: scale = $urandom_range(1, 131072);
            endcase
            program_regs(cols, rows, scale);

            n_words = $urandom_range(10, 40);
            for (int i = 0; i < n_words; i++) begin
                // occasional reloads land mid-row too
                if ($urandom_range(99) < 15)
                    queue_word(FUNC_LOAD, IDX_W'($urandom_range(255)), pick_value());
                else
                    queue_word(FUNC_MATRIX, IDX_W'($urandom_range(255)), pick_value());
            end
            random_words += n_words;
            wait_drained();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_drained();
        if (mismatches == 0)
            $display("PASS matvec_scale_round");
        else
            $display("FAIL matvec_scale_round");
        $finish;
    end

endmodule
